[sv/auac_pkg.sv]
// auac_pkg: shared types and constants of the ARP unused-address claimer.
// No dependencies.
`timescale 1ns / 1ps

package auac_pkg;

    localparam int WATCH_ENTRIES = 64;

    localparam logic [15:0] OP_REQUEST = 16'd1;
    localparam logic [15:0] OP_REPLY   = 16'd2;
    localparam logic [1:0]  OUT_OP_REQUEST = 2'd1;
    localparam logic [1:0]  OUT_OP_REPLY   = 2'd2;

    localparam logic [1:0] KIND_MIRROR   = 2'd0;
    localparam logic [1:0] KIND_CLAIM    = 2'd1;
    localparam logic [1:0] KIND_WITHHELD = 2'd2;

    localparam logic [2:0] REG_OWN_MAC  = 3'd0;
    localparam logic [2:0] REG_OWN_IP   = 3'd1;
    localparam logic [2:0] REG_SWITCH   = 3'd2;
    localparam logic [2:0] REG_PRETEND  = 3'd3;
    localparam logic [2:0] REG_MIN_GAP  = 3'd4;
    localparam logic [2:0] REG_MAX_GAP  = 3'd5;

    localparam logic [7:0]  MIN_GAP_RESET = 8'd2;
    localparam logic [15:0] MAX_GAP_RESET = 16'd60;
    localparam logic [47:0] BROADCAST_MAC = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic        command;
        logic [15:0] arp_opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [31:0] now_seconds;
        logic [5:0]  entry_slot;
        logic [31:0] entry_address;
        logic        entry_enable;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [1:0]  out_opcode;
        logic [47:0] eth_dest_mac;
        logic [47:0] arp_sender_mac;
        logic [31:0] arp_sender_ip;
        logic [47:0] arp_target_mac;
        logic [31:0] arp_target_ip;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [47:0] own_mac;
        logic [31:0] own_ip;
        logic        switch_safe;
        logic        pretend_mode;
        logic [7:0]  min_gap;
        logic [15:0] max_gap;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;        // capture accepted item, restart scan
        logic slot_write;
        logic scan_step;
        logic apply_scan;   // clear pending / apply reply, read hit slot
        logic eval;
        logic load_mirror;
        logic load_claim;
        logic last;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_command;
        logic is_request;
        logic is_reply;
        logic scan_last;
        logic target_act;
        logic eval_claim;
        logic out_free;
    } status_t;

endpackage

[sv/auac_ram.sv]
// auac_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`timescale 1ns / 1ps

module auac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/auac_dpath.sv]
// auac_dpath: watched table, scan comparator, update logic and output register.
// Depends on auac_pkg and auac_ram.
`timescale 1ns / 1ps

module auac_dpath #(
    parameter int WATCH_ENTRIES = auac_pkg::WATCH_ENTRIES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  auac_pkg::in_item_t   in_item,
    input  auac_pkg::cfg_t       cfg,
    input  auac_pkg::cmd_t       cmd,
    output auac_pkg::status_t    status,
    output auac_pkg::out_item_t  out_item,
    output logic                 out_valid,
    input  logic                 out_stall
);

    localparam int IW = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1;

    auac_pkg::in_item_t item_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] cmp_idx_reg;
    logic          cmp_v_reg;
    logic          f1_reg, f2_reg;
    logic [IW-1:0] s1_reg, s2_reg;
    logic [WATCH_ENTRIES-1:0] valid_reg, pending_reg;
    auac_pkg::out_item_t out_reg;
    logic          out_valid_reg;

    logic [31:0] wa_rdata, at_rdata, rip_rdata;
    logic [47:0] rmac_rdata;
    logic        slot_ok;
    logic [IW-1:0] slot_idx;
    logic        hit;
    logic        pend, rearm;
    logic [31:0] gap;
    logic        arm, disarm, claim, refresh;

    assign slot_ok  = ({26'd0, in_item.entry_slot} < 32'(WATCH_ENTRIES));
    assign slot_idx = IW'(item_reg.entry_slot);
    assign idx_next = idx_reg + IW'(1);

    // table of watched addresses: scanned during search, hit slot read after
    auac_ram #(.WIDTH(32), .DEPTH(WATCH_ENTRIES)) u_watched (
        .clk   (clk),
        .we    (cmd.slot_write),
        .waddr (slot_idx),
        .wdata (item_reg.entry_address),
        .raddr (cmd.scan_step ? idx_reg : s2_reg),
        .rdata (wa_rdata)
    );

    auac_ram #(.WIDTH(32), .DEPTH(WATCH_ENTRIES)) u_arm_time (
        .clk   (clk),
        .we    (arm || refresh),
        .waddr (s2_reg),
        .wdata (item_reg.now_seconds),
        .raddr (s2_reg),
        .rdata (at_rdata)
    );

    auac_ram #(.WIDTH(32), .DEPTH(WATCH_ENTRIES)) u_req_ip (
        .clk   (clk),
        .we    (arm),
        .waddr (s2_reg),
        .wdata (item_reg.sender_ip),
        .raddr (s2_reg),
        .rdata (rip_rdata)
    );

    auac_ram #(.WIDTH(48), .DEPTH(WATCH_ENTRIES)) u_req_mac (
        .clk   (clk),
        .we    (arm || (cmd.apply_scan && status.is_reply && f1_reg)),
        .waddr (arm ? s2_reg : s1_reg),
        .wdata (item_reg.sender_mac),
        .raddr (s2_reg),
        .rdata (rmac_rdata)
    );

    assign hit = cmp_v_reg && valid_reg[cmp_idx_reg];

    // repeat-request decision for the target slot
    always_comb
    begin
        pend    = pending_reg[s2_reg];
        rearm   = !pend || (rip_rdata != item_reg.sender_ip);
        gap     = item_reg.now_seconds - at_rdata;
        arm     = cmd.eval && rearm;
        disarm  = 1'b0;
        claim   = 1'b0;
        refresh = 1'b0;
        if (cmd.eval && !rearm && (item_reg.now_seconds >= at_rdata))
        begin
            if (gap > {16'd0, cfg.max_gap})
            begin
                disarm = 1'b1;
            end
            else if (gap >= {24'd0, cfg.min_gap})
            begin
                claim   = 1'b1;
                refresh = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= in_item;
        end
        if (cmd.scan_step)
        begin
            idx_reg <= idx_next;
        end
        else if (cmd.latch)
        begin
            idx_reg <= '0;
        end
        cmp_idx_reg <= idx_reg;
        if (hit && !f1_reg && (wa_rdata == item_reg.sender_ip))
        begin
            s1_reg <= cmp_idx_reg;
        end
        if (hit && !f2_reg && (wa_rdata == item_reg.target_ip))
        begin
            s2_reg <= cmp_idx_reg;
        end
        if (cmd.load_mirror)
        begin
            out_reg.frame_kind     <= auac_pkg::KIND_MIRROR;
            out_reg.out_opcode     <= auac_pkg::OUT_OP_REQUEST;
            out_reg.eth_dest_mac   <= auac_pkg::BROADCAST_MAC;
            out_reg.arp_sender_mac <= cfg.own_mac;
            out_reg.arp_sender_ip  <= cfg.own_ip;
            out_reg.arp_target_mac <= '0;
            out_reg.arp_target_ip  <= item_reg.target_ip;
            out_reg.last_of_run    <= cmd.last;
        end
        else if (cmd.load_claim)
        begin
            out_reg.frame_kind     <= cfg.pretend_mode ? auac_pkg::KIND_WITHHELD
                                                       : auac_pkg::KIND_CLAIM;
            out_reg.out_opcode     <= auac_pkg::OUT_OP_REPLY;
            out_reg.eth_dest_mac   <= rmac_rdata;
            out_reg.arp_sender_mac <= cfg.own_mac;
            out_reg.arp_sender_ip  <= wa_rdata;
            out_reg.arp_target_mac <= rmac_rdata;
            out_reg.arp_target_ip  <= rip_rdata;
            out_reg.last_of_run    <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_v_reg     <= 1'b0;
            f1_reg        <= 1'b0;
            f2_reg        <= 1'b0;
            valid_reg     <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_v_reg <= cmd.scan_step;
            if (cmd.latch)
            begin
                f1_reg <= 1'b0;
                f2_reg <= 1'b0;
            end
            else
            begin
                if (hit && (wa_rdata == item_reg.sender_ip))
                begin
                    f1_reg <= 1'b1;
                end
                if (hit && (wa_rdata == item_reg.target_ip))
                begin
                    f2_reg <= 1'b1;
                end
            end
            if (cmd.slot_write)
            begin
                valid_reg[slot_idx]   <= item_reg.entry_enable;
                pending_reg[slot_idx] <= 1'b0;
            end
            if (cmd.apply_scan && f1_reg)
            begin
                pending_reg[s1_reg] <= 1'b0;
            end
            if (arm)
            begin
                pending_reg[s2_reg] <= 1'b1;
            end
            else if (disarm)
            begin
                pending_reg[s2_reg] <= 1'b0;
            end
            if (cmd.load_mirror || cmd.load_claim)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    logic slot_ok_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            slot_ok_reg <= slot_ok;
        end
    end

    assign status.is_command = item_reg.command && slot_ok_reg;
    assign status.is_request = !item_reg.command
                               && (item_reg.arp_opcode == auac_pkg::OP_REQUEST);
    assign status.is_reply   = !item_reg.command
                               && (item_reg.arp_opcode == auac_pkg::OP_REPLY);
    assign status.scan_last  = (idx_reg == IW'(WATCH_ENTRIES - 1));
    assign status.target_act = f2_reg && (item_reg.sender_ip != 32'd0);
    assign status.eval_claim = claim;
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_item  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

[sv/auac_ctrl.sv]
// auac_ctrl: sequencing state machine of the claimer.
// Depends on auac_pkg.
`timescale 1ns / 1ps

module auac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              switch_safe,
    input  auac_pkg::status_t status,
    output auac_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SLOT   = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_LAST   = 4'd4;
    localparam logic [3:0] S_FETCH  = 4'd5;
    localparam logic [3:0] S_EVAL   = 4'd6;
    localparam logic [3:0] S_MIRROR = 4'd7;
    localparam logic [3:0] S_CLAIM  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       claim_pend_reg, claim_pend_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        claim_pend_next = claim_pend_reg;
        cmd             = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_command)
                begin
                    state_next = S_SLOT;
                end
                else if (status.is_request || status.is_reply)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SLOT:
            begin
                cmd.slot_write = 1'b1;
                state_next     = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.apply_scan = 1'b1;
                state_next = (status.is_request && status.target_act) ? S_EVAL : S_IDLE;
            end
            S_EVAL:
            begin
                cmd.eval        = 1'b1;
                claim_pend_next = status.eval_claim;
                if (switch_safe)
                begin
                    state_next = S_MIRROR;
                end
                else if (status.eval_claim)
                begin
                    state_next = S_CLAIM;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MIRROR:
            begin
                if (status.out_free)
                begin
                    cmd.load_mirror = 1'b1;
                    cmd.last        = !claim_pend_reg;
                    state_next      = claim_pend_reg ? S_CLAIM : S_IDLE;
                end
            end
            S_CLAIM:
            begin
                if (status.out_free)
                begin
                    cmd.load_claim = 1'b1;
                    cmd.last       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            claim_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            claim_pend_reg <= claim_pend_next;
        end
    end

endmodule

[sv/arp_unused_address_claimer.sv]
// ARP unused-address claimer: top level, configuration registers and wiring.
// Depends on auac_pkg, auac_ctrl, auac_dpath.
//
// Input channel (in_valid / in_stall / in_item): parsed ARP frames with a
// seconds timestamp, or commands that write a watched-table slot.
// Output channel (out_valid / out_stall / out_item): generated mirror
// requests and claim replies, up to two per frame, the last one flagged.
// APB port: six registers at byte addresses 8*i, to be written only while
// idle; the block does not enforce this. One item is in work at a time.
// A request or reply sweeps the watched-address memory one entry per
// cycle, then the target slot may be evaluated and results produced;
// results are registered in the output register before they appear. The
// sweep runs through the single read port of the address memory.
// While the receiver stalls, a held result stays in the output register and
// the block waits before loading a second result; in_stall stays high.
// Reset clears the slot valid and pending bits and loads the register
// defaults (min gap 2 s, max gap 60 s); no clearing pass is needed.
`timescale 1ns / 1ps

module arp_unused_address_claimer #(
    parameter int WATCH_ENTRIES = auac_pkg::WATCH_ENTRIES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  auac_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output auac_pkg::out_item_t out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    auac_pkg::cfg_t    cfg_reg;
    auac_pkg::cmd_t    cmd;
    auac_pkg::status_t status;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_mac      <= '0;
            cfg_reg.own_ip       <= '0;
            cfg_reg.switch_safe  <= 1'b0;
            cfg_reg.pretend_mode <= 1'b0;
            cfg_reg.min_gap      <= auac_pkg::MIN_GAP_RESET;
            cfg_reg.max_gap      <= auac_pkg::MAX_GAP_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                auac_pkg::REG_OWN_MAC: cfg_reg.own_mac      <= pwdata[47:0];
                auac_pkg::REG_OWN_IP:  cfg_reg.own_ip       <= pwdata[31:0];
                auac_pkg::REG_SWITCH:  cfg_reg.switch_safe  <= pwdata[0];
                auac_pkg::REG_PRETEND: cfg_reg.pretend_mode <= pwdata[0];
                auac_pkg::REG_MIN_GAP: cfg_reg.min_gap      <= pwdata[7:0];
                auac_pkg::REG_MAX_GAP: cfg_reg.max_gap      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            auac_pkg::REG_OWN_MAC: prdata = {16'd0, cfg_reg.own_mac};
            auac_pkg::REG_OWN_IP:  prdata = {32'd0, cfg_reg.own_ip};
            auac_pkg::REG_SWITCH:  prdata = {63'd0, cfg_reg.switch_safe};
            auac_pkg::REG_PRETEND: prdata = {63'd0, cfg_reg.pretend_mode};
            auac_pkg::REG_MIN_GAP: prdata = {56'd0, cfg_reg.min_gap};
            auac_pkg::REG_MAX_GAP: prdata = {48'd0, cfg_reg.max_gap};
            default:               prdata = '0;
        endcase
    end

    auac_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .switch_safe (cfg_reg.switch_safe),
        .status      (status),
        .cmd         (cmd)
    );

    auac_dpath #(.WATCH_ENTRIES(WATCH_ENTRIES)) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule
